/* hdl/assert_macros.svh */
// Assertion helpers; every user has clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/aed_pkg.sv */
`default_nettype none

package aed_pkg;

  localparam int CAP_W  = 5;
  localparam int ELEM_W = 8;
  localparam int OFS_W  = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef enum logic {
    SIDE_LEFT  = 1'b0,
    SIDE_RIGHT = 1'b1
  } side_t;

  // Per-item status that travels alongside the slot read data.
  typedef struct packed {
    logic             evicted;
    side_t            side;
    logic             is_read;
    logic             read_ok;
    logic [CAP_W-1:0] occupancy;
  } res_info_t;

endpackage

`default_nettype wire

/* hdl/aed_store.sv */
`default_nettype none

module aed_store #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [IW-1:0]             waddr,
  input  wire logic [aed_pkg::ELEM_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [IW-1:0]             raddr,
  output logic      [aed_pkg::ELEM_W-1:0] rdata_r
);
  import aed_pkg::*;

  logic [ELEM_W-1:0] mem [DEPTH];

  // Read-before-write: an evicted byte is seen even if the same slot is refilled.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

/* hdl/aed_ctrl.sv */
`default_nettype none
`include "assert_macros.svh"

module aed_ctrl #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [aed_pkg::CAP_W-1:0]  cfg_cap,
  input  wire logic                       acc,
  input  wire aed_pkg::cmd_t              cmd,
  input  wire logic [aed_pkg::ELEM_W-1:0] elem,
  input  wire logic [aed_pkg::OFS_W-1:0]  offset,
  output logic                            mem_we,
  output logic      [IW-1:0]              mem_waddr,
  output logic      [aed_pkg::ELEM_W-1:0] mem_wdata,
  output logic      [IW-1:0]              mem_raddr,
  output aed_pkg::res_info_t              info
);
  import aed_pkg::*;

  localparam int AW = ((IW > CAP_W) ? IW : CAP_W) + 1;
  localparam logic [AW-1:0] DEPTH_A = AW'(DEPTH);

  logic [CAP_W-1:0] cap_r;
  logic [IW-1:0]    front_r, front_nxt;
  logic [IW-1:0]    rear_r, rear_nxt;
  logic [CAP_W-1:0] count_r, count_nxt;
  side_t            turn_r, turn_nxt;

  logic [AW-1:0] size, cap_a, front_a, rear_a;
  logic [AW-1:0] f1, r1, f2, r2, rd_sum, rd_addr, ev_addr;
  logic [CAP_W-1:0] c1;
  logic full, read_ok;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x, input logic [AW-1:0] sz);
    logic [AW-1:0] y;
    y = x + AW'(1);
    return (y == sz) ? '0 : y;
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] x, input logic [AW-1:0] sz);
    return (x == '0) ? (sz - AW'(1)) : (x - AW'(1));
  endfunction

  // Active ring size: capacity clamped to 1..DEPTH.
  always_comb begin
    cap_a = AW'(cap_r);
    if (cap_r == '0) begin
      size = AW'(1);
    end else if (cap_a > DEPTH_A) begin
      size = DEPTH_A;
    end else begin
      size = cap_a;
    end
  end

  always_comb begin
    front_a = AW'(front_r);
    rear_a  = AW'(rear_r);
    full    = (AW'(count_r) >= size);

    // Eviction: turn right drops the left end, turn left drops the right end.
    ev_addr = (turn_r == SIDE_LEFT) ? front_a : rear_a;
    f1 = (full && turn_r == SIDE_LEFT)  ? wrap_inc(front_a, size) : front_a;
    r1 = (full && turn_r == SIDE_RIGHT) ? wrap_dec(rear_a, size)  : rear_a;
    c1 = full ? (size[CAP_W-1:0] - CAP_W'(1)) : count_r;

    if (c1 == '0) begin
      f2 = '0;
      r2 = '0;
    end else if (turn_r == SIDE_LEFT) begin
      f2 = f1;
      r2 = wrap_inc(r1, size);
    end else begin
      f2 = wrap_dec(f1, size);
      r2 = r1;
    end

    // Read address: front + offset, one wrap (offset < count <= size).
    rd_sum  = front_a + AW'(offset);
    rd_addr = (rd_sum >= size) ? (rd_sum - size) : rd_sum;
    read_ok = ({1'b0, offset} < count_r);
  end

  // turn_r encodes the next push side: SIDE_LEFT code (0) means push right.
  // The named constant SIDE_RIGHT equals the code for "next push goes left".
  always_comb begin
    front_nxt = front_r;
    rear_nxt  = rear_r;
    count_nxt = count_r;
    turn_nxt  = turn_r;
    mem_we    = 1'b0;
    mem_waddr = r2[IW-1:0];
    mem_wdata = elem;
    mem_raddr = (cmd == CMD_READ) ? rd_addr[IW-1:0] : ev_addr[IW-1:0];

    if (acc && cmd == CMD_PUSH) begin
      front_nxt = f2[IW-1:0];
      rear_nxt  = r2[IW-1:0];
      count_nxt = c1 + CAP_W'(1);
      turn_nxt  = side_t'(~turn_r);
      mem_we    = 1'b1;
      mem_waddr = (turn_r == SIDE_LEFT) ? r2[IW-1:0] : f2[IW-1:0];
    end

    info.evicted   = (cmd == CMD_PUSH) && full;
    info.side      = turn_r;
    info.is_read   = (cmd == CMD_READ);
    info.read_ok   = (cmd == CMD_READ) && read_ok;
    info.occupancy = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      front_r <= '0;
      rear_r  <= '0;
      count_r <= '0;
      turn_r  <= SIDE_LEFT;
    end else if (cfg_we) begin
      cap_r   <= cfg_cap;
      front_r <= '0;
      rear_r  <= '0;
      count_r <= '0;
      turn_r  <= SIDE_LEFT;
    end else begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      count_r <= count_nxt;
      turn_r  <= turn_nxt;
    end
  end

  `AED_ASSERT_NOW(a_count_in_size, 1'b1, AW'(count_r) <= size, "occupancy above ring size")
  `AED_ASSERT_NOW(a_ptr_in_size, 1'b1, (AW'(front_r) < size) && (AW'(rear_r) < size), "index outside ring")
  `AED_ASSERT_NEXT(a_push_nonempty, acc && cmd == CMD_PUSH && !cfg_we, count_r != '0, "push left deque empty")

endmodule

`default_nettype wire

/* hdl/alternating_end_deque.sv */
// Byte deque on a ring of slots whose pushes alternate ends: the first push
// after reset or after a capacity write goes to the rear (right), the next to
// the front (left), and so on. A push into a full deque first drops one byte,
// from the left when the turn is right and from the right when it is left,
// and reports it. A read item returns the byte at an offset from the front.
// Every item yields exactly one result item, in the cycle after acceptance;
// one item per cycle is sustained while out_tready is high, set by the pointer
// update and the one read port of the slot store. in_tready drops only while a
// result is held by out_tready low. cfg_ready is always high; a capacity write
// (1..DEPTH, 0 acts as 1, larger values as DEPTH) empties the deque and must be
// issued only while no item is in flight. Slots hold no reset value.
`default_nettype none

module alternating_end_deque #(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: capacity
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,  // [7:0] elem, [11:8] offset, [15:12] zero
  input  wire logic [0:0]  in_tuser,  // [0] cmd: 0 push, 1 read
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata  // [0] evicted, [1] evicted_side,
                                      // [9:2] evicted_value, [17:10] read_value,
                                      // [18] read_valid, [23:19] occupancy
);
  import aed_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              acc;
  logic              cfg_we;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr, mem_raddr;
  logic [ELEM_W-1:0] mem_wdata, rdata_r;
  res_info_t         info, info_r;
  logic              out_valid_r;
  logic [ELEM_W-1:0] ev_val, rd_val;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid;

  // The result register frees up in the same cycle it is taken downstream.
  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;

  aed_ctrl #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_cap   (cfg_data),
    .acc       (acc),
    .cmd       (cmd_t'(in_tuser[0])),
    .elem      (in_tdata[7:0]),
    .offset    (in_tdata[11:8]),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .info      (info)
  );

  // Slot store: read data is captured with the item and held while stalled.
  aed_store #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (acc),
    .raddr   (mem_raddr),
    .rdata_r (rdata_r)
  );

  // Result register: status fields ride with the slot read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      info_r <= info;
    end
  end

  // Fields that do not apply read as zero.
  assign ev_val = info_r.evicted ? rdata_r : '0;
  assign rd_val = info_r.read_ok ? rdata_r : '0;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {info_r.occupancy, info_r.read_ok, rd_val, ev_val,
                       (info_r.evicted && info_r.side == SIDE_RIGHT), info_r.evicted};

endmodule

`default_nettype wire
